// ===== rtl/h264_rtp_fu_a_packetizer_macros.svh =====
`ifndef H264_RTP_FU_A_PACKETIZER_MACROS_SVH
`define H264_RTP_FU_A_PACKETIZER_MACROS_SVH

// check cons whenever ante holds, same edge
`define H264FU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons at the next edge after ante holds
`define H264FU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/h264fu_pkg.sv =====
package h264fu_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int LIM_W      = 11;
	localparam int SEQ_W      = 16;
	localparam int SIZE_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_SEQ   = 2'd1;

	localparam logic [LIM_W-1:0] LIMIT_LO  = 11'd16;
	localparam logic [LIM_W-1:0] LIMIT_HI  = 11'd1460;
	localparam logic [LIM_W-1:0] LIMIT_RST = 11'd1400;

	localparam logic [7:0] FU_A_TYPE = 8'd28;
	localparam logic [7:0] NRI_MASK  = 8'h60;
	localparam logic [7:0] TYPE_MASK = 8'h1f;
	localparam logic [7:0] S_BIT     = 8'h80;
	localparam logic [7:0] E_BIT     = 8'h40;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic [1:0] SUB_IND  = 2'd0;
	localparam logic [1:0] SUB_FUH  = 2'd1;
	localparam logic [1:0] SUB_BODY = 2'd2;

	typedef struct packed {
		logic             triple;
		logic [7:0]       data;
		logic [7:0]       ind;
		logic [7:0]       fuh;
		logic             first;
		logic             last;
		logic             frag;
		logic [SEQ_W-1:0] seq;
	} h264fu_rec_t;

endpackage

// ===== rtl/h264fu_front.sv =====
`include "h264_rtp_fu_a_packetizer_macros.svh"

module h264fu_front #(
	parameter int NAL_LEN_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [h264fu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [h264fu_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                accept,
	input  logic [7:0]                          nal_byte,
	input  logic [h264fu_pkg::SIZE_W-1:0]       nal_size,
	input  logic                                nal_end,
	output logic                                rec_push,
	output h264fu_pkg::h264fu_rec_t             rec
);

	localparam int CW = ((NAL_LEN_WIDTH > h264fu_pkg::SIZE_W) ?
		NAL_LEN_WIDTH : h264fu_pkg::SIZE_W) + 1;
	localparam int LW = h264fu_pkg::LIM_W;

	logic [LW-1:0]                  lim_q;
	logic [h264fu_pkg::SEQ_W-1:0]   seq_q;
	logic [7:0]                     header_q;
	logic [NAL_LEN_WIDTH-1:0]       index_q;
	logic [LW-1:0]                  fill_q;
	logic                           frag_mode_q;

	logic [CW-1:0] idx_x, size_x, fill_x, remaining, size_m1, lim_x;
	logic [LW:0]   fill_p1;
	logic [LW-1:0] cfg_lim, lim_m1;
	logic          idx_zero, unit_done, hold, single, first_frag, close;
	logic [7:0]    fuh;

	assign idx_x    = CW'(index_q);
	assign size_x   = CW'(nal_size);
	assign fill_x   = CW'(fill_q);
	assign lim_x    = CW'(lim_q);
	assign idx_zero = (index_q == '0);

	assign unit_done  = nal_end || ((idx_x + CW'(1)) >= size_x);
	assign hold       = idx_zero && (size_x > lim_x);
	assign single     = !hold && (idx_zero || !frag_mode_q);
	assign first_frag = (idx_x == (fill_x + CW'(1)));
	assign remaining  = (size_x > idx_x) ? (size_x - idx_x) : CW'(1);
	assign size_m1    = size_x - CW'(1);
	assign fill_p1    = {1'b0, fill_q} + (LW+1)'(1);
	assign lim_m1     = lim_q - LW'(1);

	assign close = unit_done || (fill_p1 >= {1'b0, lim_q}) ||
		(first_frag && (size_m1 == lim_x) && (fill_p1 >= {1'b0, lim_m1}));

	always_comb begin
		fuh = header_q & h264fu_pkg::TYPE_MASK;
		if (first_frag) begin
			fuh = fuh | h264fu_pkg::S_BIT;
		end else if (remaining <= lim_x) begin
			fuh = fuh | h264fu_pkg::E_BIT;
		end
	end

	always_comb begin
		if (cfg_data[LW-1:0] < h264fu_pkg::LIMIT_LO) begin
			cfg_lim = h264fu_pkg::LIMIT_LO;
		end else if (cfg_data[LW-1:0] > h264fu_pkg::LIMIT_HI) begin
			cfg_lim = h264fu_pkg::LIMIT_HI;
		end else begin
			cfg_lim = cfg_data[LW-1:0];
		end
	end

	assign rec_push   = accept && !hold;
	assign rec.triple = !single && (fill_q == '0);
	assign rec.data   = nal_byte;
	assign rec.ind    = (header_q & h264fu_pkg::NRI_MASK) | h264fu_pkg::FU_A_TYPE;
	assign rec.fuh    = fuh;
	assign rec.first  = single && idx_zero;
	assign rec.last   = single ? unit_done : close;
	assign rec.frag   = !single;
	assign rec.seq    = seq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q       <= h264fu_pkg::LIMIT_RST;
			seq_q       <= '0;
			header_q    <= '0;
			index_q     <= '0;
			fill_q      <= '0;
			frag_mode_q <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == h264fu_pkg::REG_MAX_PAYLOAD)) begin
				lim_q <= cfg_lim;
			end
			if (cfg_we && (cfg_index == h264fu_pkg::REG_START_SEQ)) begin
				seq_q <= cfg_data[h264fu_pkg::SEQ_W-1:0];
			end else if (accept && !hold && (single ? unit_done : close)) begin
				seq_q <= seq_q + h264fu_pkg::SEQ_W'(1);
			end
			if (accept) begin
				if (hold) begin
					header_q <= nal_byte;
				end
				if (unit_done) begin
					index_q     <= '0;
					frag_mode_q <= 1'b0;
					fill_q      <= '0;
				end else begin
					index_q <= index_q + NAL_LEN_WIDTH'(1);
					if (hold) begin
						frag_mode_q <= 1'b1;
						fill_q      <= '0;
					end else if (single) begin
						if (idx_zero) begin
							frag_mode_q <= 1'b0;
						end
					end else if (close) begin
						fill_q <= '0;
					end else begin
						fill_q <= fill_p1[LW-1:0];
					end
				end
			end
		end
	end

	`H264FU_ASSERT_NOW(a_mode_rise_fill, $rose(frag_mode_q), fill_q == '0, "fragment mode entered with fill")
	`H264FU_ASSERT_NEXT(a_hold_keeps_seq, accept && hold && !cfg_we, seq_q == $past(seq_q), "held header moved sequence")
	`H264FU_ASSERT_NOW(a_triple_is_frag, rec_push && rec.triple, rec.frag && !rec.first, "fragment start not marked as fragment")

endmodule

// ===== rtl/h264fu_queue.sv =====
`include "h264_rtp_fu_a_packetizer_macros.svh"

module h264fu_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  h264fu_pkg::h264fu_rec_t wr_data,
	output logic                    full,
	input  logic                    rd_en,
	output h264fu_pkg::h264fu_rec_t rd_data,
	output logic                    empty
);

	localparam int PW = h264fu_pkg::QPTR_W;

	h264fu_pkg::h264fu_rec_t entry_q [h264fu_pkg::QUEUE_DEPTH];
	logic [PW:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0] count;

	assign count   = wr_ptr_q - rd_ptr_q;
	assign empty   = (wr_ptr_q == rd_ptr_q);
	assign full    = (wr_ptr_q[PW-1:0] == rd_ptr_q[PW-1:0]) && (wr_ptr_q[PW] != rd_ptr_q[PW]);
	assign rd_data = entry_q[rd_ptr_q[PW-1:0]];

	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			entry_q[wr_ptr_q[PW-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en && !full) begin
				wr_ptr_q <= wr_ptr_q + (PW+1)'(1);
			end
			if (rd_en && !empty) begin
				rd_ptr_q <= rd_ptr_q + (PW+1)'(1);
			end
		end
	end

	`H264FU_ASSERT_NOW(a_count_bound, 1'b1, count <= (PW+1)'(h264fu_pkg::QUEUE_DEPTH), "queue count out of range")

endmodule

// ===== rtl/h264fu_back.sv =====
`include "h264_rtp_fu_a_packetizer_macros.svh"

module h264fu_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  h264fu_pkg::h264fu_rec_t           head,
	input  logic                              q_empty,
	output logic                              q_pop,
	input  logic                              pop,
	output logic                              empty,
	output logic [7:0]                        payload_byte,
	output logic                              packet_first,
	output logic                              packet_last,
	output logic [h264fu_pkg::SEQ_W-1:0]      seq_number,
	output logic                              is_fragment,
	output logic                              run_last
);

	logic       out_valid_q;
	logic [1:0] sub_q;
	logic       load, last_sub;
	logic [7:0] sel_byte;
	logic       sel_first, sel_last;

	assign load     = !q_empty && (!out_valid_q || pop);
	assign last_sub = head.triple ? (sub_q == h264fu_pkg::SUB_BODY) : 1'b1;
	assign q_pop    = load && last_sub;
	assign empty    = !out_valid_q;

	always_comb begin
		sel_byte  = head.data;
		sel_first = head.first;
		sel_last  = head.last;
		if (head.triple) begin
			case (sub_q)
				h264fu_pkg::SUB_IND: begin
					sel_byte  = head.ind;
					sel_first = 1'b1;
					sel_last  = 1'b0;
				end
				h264fu_pkg::SUB_FUH: begin
					sel_byte  = head.fuh;
					sel_first = 1'b0;
					sel_last  = 1'b0;
				end
				default: begin
					sel_byte  = head.data;
					sel_first = head.first;
					sel_last  = head.last;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			payload_byte <= sel_byte;
			packet_first <= sel_first;
			packet_last  <= sel_last;
			seq_number   <= head.seq;
			is_fragment  <= head.frag;
			run_last     <= last_sub;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= h264fu_pkg::SUB_IND;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				sub_q <= last_sub ? h264fu_pkg::SUB_IND : (sub_q + 2'd1);
			end
		end
	end

	`H264FU_ASSERT_NOW(a_sub_needs_head, sub_q != h264fu_pkg::SUB_IND, !q_empty && head.triple, "partial record without head")
	`H264FU_ASSERT_NOW(a_sub_range, 1'b1, sub_q != 2'd3, "sub index out of range")

endmodule

// ===== rtl/h264_rtp_fu_a_packetizer.sv =====
// channel   direction  handshake            beat
// input     in         push / full          nal_byte, nal_size, nal_end
// result    out        pop / empty          payload_byte .. run_last
// config    in         cfg_we (no wait)     cfg_index, cfg_data
//
// One NAL byte is taken per cycle while the record queue has room.
// A fragment's first body byte yields three beats (indicator, FU header,
// body); every other byte yields one beat, a held header none.
// Result beats leave from an output register loaded from the queue head.
// Reset empties the queue, drops the output valid flag and resets the packetizer state.
// Either side may stall freely; the queue absorbs the difference.

module h264_rtp_fu_a_packetizer #(
	parameter int NAL_LEN_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [h264fu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [h264fu_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                              push,
	output logic                              full,
	input  logic [7:0]                        nal_byte,
	input  logic [h264fu_pkg::SIZE_W-1:0]     nal_size,
	input  logic                              nal_end,
	output logic                              empty,
	input  logic                              pop,
	output logic [7:0]                        payload_byte,
	output logic                              packet_first,
	output logic                              packet_last,
	output logic [h264fu_pkg::SEQ_W-1:0]      seq_number,
	output logic                              is_fragment,
	output logic                              run_last
);

	h264fu_pkg::h264fu_rec_t rec, head;
	logic rec_push, q_empty, q_pop, accept;

	assign accept = push && !full;

	h264fu_front #(
		.NAL_LEN_WIDTH(NAL_LEN_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.nal_byte (nal_byte),
		.nal_size (nal_size),
		.nal_end  (nal_end),
		.rec_push (rec_push),
		.rec      (rec)
	);

	h264fu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (rec_push),
		.wr_data(rec),
		.full   (full),
		.rd_en  (q_pop),
		.rd_data(head),
		.empty  (q_empty)
	);

	h264fu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.payload_byte(payload_byte),
		.packet_first(packet_first),
		.packet_last (packet_last),
		.seq_number  (seq_number),
		.is_fragment (is_fragment),
		.run_last    (run_last)
	);

endmodule
